[rtl/bicycle_kinematic_odometry_step_top_macros.svh]
// Assertion macros for the odometry step block.
`ifndef BICYCLE_KINEMATIC_ODOMETRY_STEP_TOP_MACROS_SVH
`define BICYCLE_KINEMATIC_ODOMETRY_STEP_TOP_MACROS_SVH

// Condition holds at every edge outside reset.
`define BKOS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent is checked after the antecedent, via the non-overlapped implication.
`define BKOS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/bkos_pkg.sv]
`default_nettype none
package bkos_pkg;

   localparam int CORDIC_STEPS = 30;
   localparam int MUL_STEPS    = 32;
   localparam int DIV_STEPS    = 64;

   localparam logic [63:0]        INV_GAIN_Q30 = 64'd652032874;
   localparam logic signed [35:0] PI_Q30       = 36'sd3373259426;
   localparam logic signed [35:0] HALF_PI_Q30  = 36'sd1686629713;
   localparam logic signed [35:0] TWO_PI_Q30   = 36'sd6746518852;
   localparam logic signed [17:0] PI_Q13       = 18'sd25736;
   localparam logic signed [17:0] TWO_PI_Q13   = 18'sd51472;
   localparam logic signed [14:0] STEER_LIMIT  = 15'sd12288;

   // floor(2^47 / 51472), reciprocal for the 2*pi reduction of the heading delta
   localparam logic [63:0] MOD_RECIP = 64'd2734253348;

   localparam logic [15:0] WHEELBASE_RESET     = 16'd256;
   localparam logic [15:0] REAR_DISTANCE_RESET = 16'd128;
   localparam logic [15:0] SAMPLE_TIME_RESET   = 16'd6554;

   typedef enum logic [1:0] {
      CSR_WHEELBASE     = 2'd0,
      CSR_REAR_DISTANCE = 2'd1,
      CSR_SAMPLE_TIME   = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROT_STEER,
      ST_MUL_A,
      ST_MUL_B,
      ST_VEC,
      ST_MUL_R,
      ST_ROT_HEAD,
      ST_MUL_VDT,
      ST_MUL_X,
      ST_MUL_Y,
      ST_MUL_NUM,
      ST_DIV_Q,
      ST_MUL_QE,
      ST_MUL_QC,
      ST_FINISH
   } state_type;

   typedef enum logic {
      MD_MUL,
      MD_DIV
   } md_op_type;

   typedef struct packed {
      logic               start;
      logic               vec;
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
   } cordic_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
   } cordic_rsp_type;

   // mul: a * b[31:0], negated if neg. div: b / a[31:0].
   typedef struct packed {
      logic        start;
      md_op_type   op;
      logic        neg;
      logic [63:0] a;
      logic [63:0] b;
   } md_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] acc;
      logic [63:0] quo;
   } md_rsp_type;

   function automatic logic signed [63:0] atan_q30(input logic [4:0] idx);
      logic [31:0] t;
      case (idx)
         5'd0:  t = 32'h3243F6A8;
         5'd1:  t = 32'h1DAC6705;
         5'd2:  t = 32'h0FADBAFC;
         5'd3:  t = 32'h07F56EA6;
         5'd4:  t = 32'h03FEAB76;
         5'd5:  t = 32'h01FFD55B;
         5'd6:  t = 32'h00FFFAAA;
         5'd7:  t = 32'h007FFF55;
         5'd8:  t = 32'h003FFFEA;
         5'd9:  t = 32'h001FFFFD;
         5'd10: t = 32'h000FFFFF;
         5'd11: t = 32'h0007FFFF;
         5'd12: t = 32'h0003FFFF;
         5'd13: t = 32'h0001FFFF;
         5'd14: t = 32'h0000FFFF;
         5'd15: t = 32'h00007FFF;
         5'd16: t = 32'h00003FFF;
         5'd17: t = 32'h00001FFF;
         5'd18: t = 32'h00000FFF;
         5'd19: t = 32'h000007FF;
         5'd20: t = 32'h000003FF;
         5'd21: t = 32'h000001FF;
         5'd22: t = 32'h000000FF;
         5'd23: t = 32'h0000007F;
         5'd24: t = 32'h0000003F;
         5'd25: t = 32'h0000001F;
         5'd26: t = 32'h0000000F;
         5'd27: t = 32'h00000008;
         5'd28: t = 32'h00000004;
         5'd29: t = 32'h00000002;
         default: t = 32'h00000000;
      endcase
      return {32'h0, t};
   endfunction

endpackage
`default_nettype wire

[rtl/bkos_cordic.sv]
`default_nettype none
// Iterative CORDIC, rotation or vectoring, one micro-rotation per cycle.
module bkos_cordic (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire bkos_pkg::cordic_req_type req,
   output bkos_pkg::cordic_rsp_type      rsp
);

   localparam logic [4:0] LAST_STEP = 5'(bkos_pkg::CORDIC_STEPS - 1);

   logic signed [63:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic               vec_ff, vec_in;
   logic [4:0]         i_ff, i_in;
   logic               busy_ff, busy_in, done_ff, done_in;

   logic signed [63:0] xs, ys, at;
   logic               dir;

   always_comb begin
      xs  = x_ff >>> i_ff;
      ys  = y_ff >>> i_ff;
      at  = bkos_pkg::atan_q30(i_ff);
      // dir high: rotate counterclockwise
      dir = vec_ff ? y_ff[63] : ~z_ff[63];

      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      vec_in  = vec_ff;
      i_in    = i_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         x_in    = req.x;
         y_in    = req.y;
         z_in    = req.z;
         vec_in  = req.vec;
         i_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (dir) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         if (i_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            i_in = i_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      vec_ff <= vec_in;
      i_ff   <= i_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.x    = x_ff;
   assign rsp.y    = y_ff;
   assign rsp.z    = z_ff;

endmodule
`default_nettype wire

[rtl/bkos_muldiv.sv]
`default_nettype none
// Shift-add multiplier and restoring divider, one bit per cycle.
module bkos_muldiv (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire bkos_pkg::md_req_type req,
   output bkos_pkg::md_rsp_type      rsp
);

   logic [63:0]         acc_ff, acc_in, opa_ff, opa_in, opb_ff, opb_in;
   logic [6:0]          cnt_ff, cnt_in;
   bkos_pkg::md_op_type op_ff, op_in;
   logic                busy_ff, busy_in, done_ff, done_in;

   logic [32:0] trial;
   logic        ge;

   always_comb begin
      trial = {acc_ff[31:0], opb_ff[63]};
      ge    = trial >= {1'b0, opa_ff[31:0]};

      acc_in  = acc_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         acc_in  = '0;
         op_in   = req.op;
         opb_in  = req.b;
         busy_in = 1'b1;
         if (req.op == bkos_pkg::MD_MUL) begin
            opa_in = req.neg ? (~req.a + 64'd1) : req.a;
            cnt_in = 7'(bkos_pkg::MUL_STEPS);
         end else begin
            opa_in = req.a;
            cnt_in = 7'(bkos_pkg::DIV_STEPS);
         end
      end else if (busy_ff) begin
         if (op_ff == bkos_pkg::MD_MUL) begin
            if (opb_ff[0]) acc_in = acc_ff + opa_ff;
            opa_in = {opa_ff[62:0], 1'b0};
            opb_in = {1'b0, opb_ff[63:1]};
         end else begin
            acc_in = {31'b0, ge ? (trial - {1'b0, opa_ff[31:0]}) : trial};
            opb_in = {opb_ff[62:0], ge};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      cnt_ff <= cnt_in;
      op_ff  <= op_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.acc  = acc_ff;
   assign rsp.quo  = opb_ff;

endmodule
`default_nettype wire

[rtl/bicycle_kinematic_odometry_step_top.sv]
// Kinematic bicycle odometry, one Euler step per input beat.
// Each beat runs three 30-step CORDIC passes, nine 32-step multiplies and one 64-step
// divide, one at a time, each issued by a start strobe, then loads the result register.
// A new beat is accepted only once the previous one has reached the result register;
// the next beat is taken while a result waits, and the finish state stalls while the
// previous result is still unaccepted.
// Reset (synchronous, high): x, y, heading cleared, registers to defaults, idle.
`default_nettype none
`include "bicycle_kinematic_odometry_step_top_macros.svh"
module bicycle_kinematic_odometry_step_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // speed_in[15:0], steer_angle[30:16], pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // pos_x[31:0], pos_y[63:32], heading[79:64]
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // ---------------- configuration registers ----------------
   logic [15:0] wheelbase_ff, wheelbase_in;
   logic [15:0] rear_ff, rear_in;
   logic [15:0] dt_ff, dt_in;
   logic        csr_wr;
   bkos_pkg::csr_index_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = bkos_pkg::csr_index_type'(csr_paddr[3:2]);

   always_comb begin
      wheelbase_in = wheelbase_ff;
      rear_in      = rear_ff;
      dt_in        = dt_ff;
      csr_prdata   = '0;
      unique case (csr_idx)
         bkos_pkg::CSR_WHEELBASE: begin
            csr_prdata = {16'h0, wheelbase_ff};
            if (csr_wr) wheelbase_in = csr_pwdata[15:0];
         end
         bkos_pkg::CSR_REAR_DISTANCE: begin
            csr_prdata = {16'h0, rear_ff};
            if (csr_wr) rear_in = csr_pwdata[15:0];
         end
         bkos_pkg::CSR_SAMPLE_TIME: begin
            csr_prdata = {16'h0, dt_ff};
            if (csr_wr) dt_in = csr_pwdata[15:0];
         end
         default: csr_prdata = '0;   // unmapped: writes dropped
      endcase
   end

   // ---------------- datapath state ----------------
   bkos_pkg::state_type state_ff, state_in;
   logic go_ff, go_in;               // first cycle of a unit op: issue start

   logic signed [15:0] v_ff, v_in;
   logic signed [14:0] st_ff, st_in;
   logic signed [31:0] cs_ff, cs_in, sn_ff, sn_in, hc_ff, hc_in, hs_ff, hs_in;
   logic signed [47:0] a_ff, a_in, b_ff, b_in;
   logic signed [63:0] mag_ff, mag_in;
   logic signed [31:0] slip_ff, slip_in;
   logic [31:0]        r_ff, r_in;
   logic signed [31:0] vdt_ff, vdt_in;
   logic [63:0]        u_ff, u_in, q_ff, q_in;
   logic [31:0]        qe_ff, qe_in;
   logic               nneg_ff, nneg_in, rneg_ff, rneg_in;
   logic [15:0]        d_ff, d_in;
   logic signed [31:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic signed [15:0] acc_heading_ff, acc_heading_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [79:0]        rsp_data_ff, rsp_data_in;

   bkos_pkg::cordic_req_type cordic_req;
   bkos_pkg::cordic_rsp_type cordic_rsp;
   bkos_pkg::md_req_type     md_req;
   bkos_pkg::md_rsp_type     md_rsp;

   bkos_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .req   (cordic_req),
      .rsp   (cordic_rsp)
   );

   bkos_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .req   (md_req),
      .rsp   (md_rsp)
   );

   assign req_tready = (state_ff == bkos_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   function automatic logic signed [31:0] sat32(input logic signed [32:0] s);
      if (s > 33'sd2147483647)       return 32'sh7FFFFFFF;
      else if (s < -33'sd2147483648) return 32'sh80000000;
      else                           return s[31:0];
   endfunction

   // ---------------- rotation angle setup ----------------
   // Angle in Q30, wrapped into [-pi, pi], then folded into [-pi/2, pi/2]
   // with a result negation flag.
   logic signed [35:0] rot_ang, ang_wrap, rot_z;
   logic               rot_neg;
   logic signed [14:0] st_raw, st_sat;
   logic [15:0]        l_eff;
   logic [63:0]        mag_pos;
   logic [31:0]        vdt_abs;
   logic signed [63:0] prod, px, py;
   logic signed [63:0] cx, cy;
   logic signed [17:0] hsum, hwrap;
   logic [31:0]        r_raw;
   logic [16:0]        rem17;

   always_comb begin
      if (state_ff == bkos_pkg::ST_ROT_STEER)
         rot_ang = {{4{st_ff[14]}}, st_ff, 17'b0};
      else
         rot_ang = {{3{acc_heading_ff[15]}}, acc_heading_ff, 17'b0}
                   + {{4{slip_ff[31]}}, slip_ff};
      if (rot_ang > bkos_pkg::PI_Q30)       ang_wrap = rot_ang - bkos_pkg::TWO_PI_Q30;
      else if (rot_ang < -bkos_pkg::PI_Q30) ang_wrap = rot_ang + bkos_pkg::TWO_PI_Q30;
      else                                  ang_wrap = rot_ang;
      rot_neg = 1'b1;
      if (ang_wrap > bkos_pkg::HALF_PI_Q30)       rot_z = ang_wrap - bkos_pkg::PI_Q30;
      else if (ang_wrap < -bkos_pkg::HALF_PI_Q30) rot_z = ang_wrap + bkos_pkg::PI_Q30;
      else begin
         rot_z   = ang_wrap;
         rot_neg = 1'b0;
      end
   end

   // ---------------- unit requests ----------------
   always_comb begin
      mag_pos = mag_ff[63] ? 64'd0 : mag_ff;
      vdt_abs = vdt_ff[31] ? (~vdt_ff + 32'd1) : vdt_ff;

      cordic_req.start = 1'b0;
      cordic_req.vec   = (state_ff == bkos_pkg::ST_VEC);
      cordic_req.x     = $signed(bkos_pkg::INV_GAIN_Q30);
      cordic_req.y     = '0;
      cordic_req.z     = {{28{rot_z[35]}}, rot_z};

      md_req.start = 1'b0;
      md_req.op    = bkos_pkg::MD_MUL;
      md_req.neg   = 1'b0;
      md_req.a     = '0;
      md_req.b     = '0;

      case (state_ff)
         bkos_pkg::ST_ROT_STEER, bkos_pkg::ST_ROT_HEAD: cordic_req.start = go_ff;
         bkos_pkg::ST_VEC: begin
            cordic_req.start = go_ff;
            cordic_req.x     = {{16{b_ff[47]}}, b_ff};
            cordic_req.y     = {{16{a_ff[47]}}, a_ff};
            cordic_req.z     = '0;
         end
         bkos_pkg::ST_MUL_A: begin
            md_req.start = go_ff;
            md_req.a     = {{32{sn_ff[31]}}, sn_ff};
            md_req.b     = {48'h0, rear_ff};
         end
         bkos_pkg::ST_MUL_B: begin
            md_req.start = go_ff;
            md_req.a     = {{32{cs_ff[31]}}, cs_ff};
            md_req.b     = {48'h0, l_eff};
         end
         bkos_pkg::ST_MUL_R: begin
            md_req.start = go_ff;
            md_req.a     = {16'h0, mag_pos[63:16]};
            md_req.b     = bkos_pkg::INV_GAIN_Q30;
         end
         bkos_pkg::ST_MUL_VDT: begin
            md_req.start = go_ff;
            md_req.a     = {{48{v_ff[15]}}, v_ff};
            md_req.b     = {48'h0, dt_ff};
         end
         bkos_pkg::ST_MUL_X: begin
            md_req.start = go_ff;
            md_req.neg   = vdt_ff[31];
            md_req.a     = {{32{hc_ff[31]}}, hc_ff};
            md_req.b     = {32'h0, vdt_abs};
         end
         bkos_pkg::ST_MUL_Y: begin
            md_req.start = go_ff;
            md_req.neg   = vdt_ff[31];
            md_req.a     = {{32{hs_ff[31]}}, hs_ff};
            md_req.b     = {32'h0, vdt_abs};
         end
         bkos_pkg::ST_MUL_NUM: begin
            md_req.start = go_ff;
            md_req.neg   = vdt_ff[31];
            md_req.a     = {{32{sn_ff[31]}}, sn_ff};
            md_req.b     = {32'h0, vdt_abs};
         end
         bkos_pkg::ST_DIV_Q: begin
            md_req.start = go_ff;
            md_req.op    = bkos_pkg::MD_DIV;
            md_req.a     = {32'h0, r_ff};
            md_req.b     = u_ff;
         end
         bkos_pkg::ST_MUL_QE: begin
            // quotient estimate by 2*pi: (n >> 11) * floor(2^47 / 51472) >> 36,
            // low by at most one
            md_req.start = go_ff;
            md_req.a     = {11'h0, q_ff[63:11]};
            md_req.b     = bkos_pkg::MOD_RECIP;
         end
         bkos_pkg::ST_MUL_QC: begin
            md_req.start = go_ff;
            md_req.a     = {32'h0, qe_ff};
            md_req.b     = 64'(bkos_pkg::TWO_PI_Q13);
         end
         default: ;
      endcase
   end

   // ---------------- sequencer ----------------
   always_comb begin
      st_raw = req_tdata[30:16];
      if (st_raw > bkos_pkg::STEER_LIMIT)       st_sat = bkos_pkg::STEER_LIMIT;
      else if (st_raw < -bkos_pkg::STEER_LIMIT) st_sat = -bkos_pkg::STEER_LIMIT;
      else                                      st_sat = st_raw;
      l_eff = (wheelbase_ff == 16'h0) ? 16'd1 : wheelbase_ff;

      prod  = $signed(md_rsp.acc);
      px    = prod + 64'sd137438953472;     // + 2^37, then floor by 38
      py    = px;
      cx    = rneg_ff ? -cordic_rsp.x : cordic_rsp.x;
      cy    = rneg_ff ? -cordic_rsp.y : cordic_rsp.y;
      r_raw = md_rsp.acc[61:30];
      // remainder n - qe * 2pi lies in [0, 2 * 2pi), so 17 low bits hold it
      rem17 = q_ff[16:0] - md_rsp.acc[16:0];
      hsum  = nneg_ff ? ({{2{acc_heading_ff[15]}}, acc_heading_ff} - $signed({2'b0, d_ff}))
                      : ({{2{acc_heading_ff[15]}}, acc_heading_ff} + $signed({2'b0, d_ff}));
      if (hsum > bkos_pkg::PI_Q13)       hwrap = hsum - bkos_pkg::TWO_PI_Q13;
      else if (hsum < -bkos_pkg::PI_Q13) hwrap = hsum + bkos_pkg::TWO_PI_Q13;
      else                               hwrap = hsum;

      state_in       = state_ff;
      go_in          = 1'b0;
      v_in           = v_ff;
      st_in          = st_ff;
      cs_in          = cs_ff;
      sn_in          = sn_ff;
      hc_in          = hc_ff;
      hs_in          = hs_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      mag_in         = mag_ff;
      slip_in        = slip_ff;
      r_in           = r_ff;
      vdt_in         = vdt_ff;
      u_in           = u_ff;
      q_in           = q_ff;
      qe_in          = qe_ff;
      nneg_in        = nneg_ff;
      rneg_in        = (cordic_req.start && !cordic_req.vec) ? rot_neg : rneg_ff;
      d_in           = d_ff;
      acc_x_in       = acc_x_ff;
      acc_y_in       = acc_y_ff;
      acc_heading_in = acc_heading_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;
      rsp_data_in    = rsp_data_ff;

      unique case (state_ff)
         bkos_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               v_in     = req_tdata[15:0];
               st_in    = st_sat;
               state_in = bkos_pkg::ST_ROT_STEER;
               go_in    = 1'b1;
            end
         end
         bkos_pkg::ST_ROT_STEER: begin
            if (cordic_rsp.done) begin
               cs_in    = cx[31:0];
               sn_in    = cy[31:0];
               state_in = bkos_pkg::ST_MUL_A;
               go_in    = 1'b1;
            end
         end
         bkos_pkg::ST_MUL_A: begin
            if (md_rsp.done) begin
               a_in     = prod[47:0];
               state_in = bkos_pkg::ST_MUL_B;
               go_in    = 1'b1;
            end
         end
         bkos_pkg::ST_MUL_B: begin
            if (md_rsp.done) begin
               b_in     = (prod < 64'sd1) ? 48'sd1 : prod[47:0];
               state_in = bkos_pkg::ST_VEC;
               go_in    = 1'b1;
            end
         end
         bkos_pkg::ST_VEC: begin
            if (cordic_rsp.done) begin
               mag_in   = cordic_rsp.x;
               slip_in  = cordic_rsp.z[31:0];
               state_in = bkos_pkg::ST_MUL_R;
               go_in    = 1'b1;
            end
         end
         bkos_pkg::ST_MUL_R: begin
            if (md_rsp.done) begin
               r_in     = (r_raw == 32'h0) ? 32'd1 : r_raw;
               state_in = bkos_pkg::ST_ROT_HEAD;
               go_in    = 1'b1;
            end
         end
         bkos_pkg::ST_ROT_HEAD: begin
            if (cordic_rsp.done) begin
               hc_in    = cx[31:0];
               hs_in    = cy[31:0];
               state_in = bkos_pkg::ST_MUL_VDT;
               go_in    = 1'b1;
            end
         end
         bkos_pkg::ST_MUL_VDT: begin
            if (md_rsp.done) begin
               vdt_in   = prod[31:0];
               state_in = bkos_pkg::ST_MUL_X;
               go_in    = 1'b1;
            end
         end
         bkos_pkg::ST_MUL_X: begin
            if (md_rsp.done) begin
               acc_x_in = sat32({acc_x_ff[31], acc_x_ff}
                                + {{7{px[63]}}, px[63:38]});
               state_in = bkos_pkg::ST_MUL_Y;
               go_in    = 1'b1;
            end
         end
         bkos_pkg::ST_MUL_Y: begin
            if (md_rsp.done) begin
               acc_y_in = sat32({acc_y_ff[31], acc_y_ff}
                                + {{7{py[63]}}, py[63:38]});
               state_in = bkos_pkg::ST_MUL_NUM;
               go_in    = 1'b1;
            end
         end
         bkos_pkg::ST_MUL_NUM: begin
            if (md_rsp.done) begin
               nneg_in  = prod[63];
               u_in     = prod[63] ? (~md_rsp.acc + 64'd1) : md_rsp.acc;
               state_in = bkos_pkg::ST_DIV_Q;
               go_in    = 1'b1;
            end
         end
         bkos_pkg::ST_DIV_Q: begin
            if (md_rsp.done) begin
               // rounded Q13 delta magnitude
               q_in     = (md_rsp.quo + 64'd262144) >> 19;
               state_in = bkos_pkg::ST_MUL_QE;
               go_in    = 1'b1;
            end
         end
         bkos_pkg::ST_MUL_QE: begin
            if (md_rsp.done) begin
               qe_in    = {4'h0, md_rsp.acc[63:36]};
               state_in = bkos_pkg::ST_MUL_QC;
               go_in    = 1'b1;
            end
         end
         bkos_pkg::ST_MUL_QC: begin
            if (md_rsp.done) begin
               d_in     = (rem17 >= 17'(bkos_pkg::TWO_PI_Q13))
                          ? 16'(rem17 - 17'(bkos_pkg::TWO_PI_Q13)) : rem17[15:0];
               state_in = bkos_pkg::ST_FINISH;
            end
         end
         bkos_pkg::ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               acc_heading_in = hwrap[15:0];
               rsp_valid_in   = 1'b1;
               rsp_data_in    = {hwrap[15:0], acc_y_ff, acc_x_ff};
               state_in       = bkos_pkg::ST_IDLE;
            end
         end
         default: state_in = bkos_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bkos_pkg::ST_IDLE;
         go_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         acc_x_ff       <= '0;
         acc_y_ff       <= '0;
         acc_heading_ff <= '0;
         wheelbase_ff   <= bkos_pkg::WHEELBASE_RESET;
         rear_ff        <= bkos_pkg::REAR_DISTANCE_RESET;
         dt_ff          <= bkos_pkg::SAMPLE_TIME_RESET;
      end else begin
         state_ff       <= state_in;
         go_ff          <= go_in;
         rsp_valid_ff   <= rsp_valid_in;
         acc_x_ff       <= acc_x_in;
         acc_y_ff       <= acc_y_in;
         acc_heading_ff <= acc_heading_in;
         wheelbase_ff   <= wheelbase_in;
         rear_ff        <= rear_in;
         dt_ff          <= dt_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      st_ff       <= st_in;
      cs_ff       <= cs_in;
      sn_ff       <= sn_in;
      hc_ff       <= hc_in;
      hs_ff       <= hs_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      mag_ff      <= mag_in;
      slip_ff     <= slip_in;
      r_ff        <= r_in;
      vdt_ff      <= vdt_in;
      u_ff        <= u_in;
      q_ff        <= q_in;
      qe_ff       <= qe_in;
      nneg_ff     <= nneg_in;
      rneg_ff     <= rneg_in;
      d_ff        <= d_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------- assertions ----------------
   `BKOS_ASSERT_ALWAYS(a_one_unit, clock, reset, !(cordic_rsp.busy && md_rsp.busy), "both units busy")
   `BKOS_ASSERT_ALWAYS(a_head_range, clock, reset, (acc_heading_ff <= 16'sd25736) && (acc_heading_ff >= -16'sd25736), "heading out of range")
   `BKOS_ASSERT_NEXT(a_accept_start, clock, reset, req_tvalid && req_tready, (state_ff == bkos_pkg::ST_ROT_STEER) && go_ff, "accept did not start sequence")

endmodule
`default_nettype wire
